/* rtl/jets_pkg.sv */
`timescale 1ns / 1ps
// jets_pkg: shared types and constants of the joystick event tracker
// used by every module in rtl/, depends on nothing
package jets_pkg;

    localparam int AXIS_W     = 11;
    localparam int RAW_W      = 32;
    localparam int DIFF_W     = RAW_W + 1;
    localparam int REM_W      = DIFF_W + AXIS_W;
    localparam int QUOT_W     = AXIS_W + 1;
    localparam int CODE_W     = 10;
    localparam int EV_W       = 16;
    localparam int STATUS_W   = 28;
    localparam int NUM_BTN    = 4;
    localparam int REG_IDX_W  = 3;
    localparam int STEP_W     = 4;

    localparam logic [AXIS_W-1:0] AXIS_FULL = 11'h7FF;
    localparam logic [STEP_W-1:0] LAST_STEP = 4'd11;

    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [EV_W-1:0] TYPE_KEY = 16'd1;
    localparam logic [EV_W-1:0] TYPE_ABS = 16'd3;
    localparam logic [EV_W-1:0] CODE_X   = 16'd0;
    localparam logic [EV_W-1:0] CODE_Y   = 16'd1;

    localparam logic [REG_IDX_W-1:0] REG_BTN_A = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BTN_B = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BTN_C = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BTN_D = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_X_MIN = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_X_MAX = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_Y_MIN = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_Y_MAX = 3'd7;

    typedef struct packed {
        logic [NUM_BTN-1:0][CODE_W-1:0] btn_code;
        logic [RAW_W-1:0]               x_min;
        logic [RAW_W-1:0]               x_max;
        logic [RAW_W-1:0]               y_min;
        logic [RAW_W-1:0]               y_max;
    } jets_cfg_t;

    typedef struct packed {
        logic             start;
        logic [RAW_W-1:0] value;
        logic [RAW_W-1:0] lo;
        logic [RAW_W-1:0] hi;
    } jets_scl_req_t;

    typedef struct packed {
        logic              done;
        logic [AXIS_W-1:0] result;
    } jets_scl_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_X_GO,
        ST_X_WAIT,
        ST_Y_GO,
        ST_Y_WAIT,
        ST_OUT
    } jets_state_t;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_SUB,
        SC_ABS,
        SC_MUL,
        SC_DIV,
        SC_DONE
    } jets_scl_state_t;

endpackage

/* rtl/jets_cfg.sv */
`timescale 1ns / 1ps
// jets_cfg: configuration register file (button codes and axis ranges)
// depends on jets_pkg
module jets_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [jets_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [jets_pkg::RAW_W-1:0]      cfg_wdata,
    output jets_pkg::jets_cfg_t             cfg
);

    jets_pkg::jets_cfg_t cfg_reg;
    jets_pkg::jets_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                jets_pkg::REG_BTN_A: cfg_next.btn_code[0] = cfg_wdata[jets_pkg::CODE_W-1:0];
                jets_pkg::REG_BTN_B: cfg_next.btn_code[1] = cfg_wdata[jets_pkg::CODE_W-1:0];
                jets_pkg::REG_BTN_C: cfg_next.btn_code[2] = cfg_wdata[jets_pkg::CODE_W-1:0];
                jets_pkg::REG_BTN_D: cfg_next.btn_code[3] = cfg_wdata[jets_pkg::CODE_W-1:0];
                jets_pkg::REG_X_MIN: cfg_next.x_min = cfg_wdata;
                jets_pkg::REG_X_MAX: cfg_next.x_max = cfg_wdata;
                jets_pkg::REG_Y_MIN: cfg_next.y_min = cfg_wdata;
                jets_pkg::REG_Y_MAX: cfg_next.y_max = cfg_wdata;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.btn_code[0] <= 10'd288;
            cfg_reg.btn_code[1] <= 10'd289;
            cfg_reg.btn_code[2] <= 10'd290;
            cfg_reg.btn_code[3] <= 10'd291;
            cfg_reg.x_min       <= 32'd0;
            cfg_reg.x_max       <= 32'd2047;
            cfg_reg.y_min       <= 32'd0;
            cfg_reg.y_max       <= 32'd2047;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/jets_scaler.sv */
`timescale 1ns / 1ps
// jets_scaler: maps a raw axis value onto 0..2047 with one shared
// compare/subtract unit, one quotient bit per cycle; depends on jets_pkg
module jets_scaler (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  jets_pkg::jets_scl_req_t req,
    output jets_pkg::jets_scl_rsp_t rsp
);

    localparam int DIFF_W = jets_pkg::DIFF_W;
    localparam int REM_W  = jets_pkg::REM_W;
    localparam int QUOT_W = jets_pkg::QUOT_W;
    localparam int AXIS_W = jets_pkg::AXIS_W;

    jets_pkg::jets_scl_state_t state_reg, state_next;

    logic [DIFF_W-1:0]         diff_reg, diff_next;
    logic [DIFF_W-1:0]         den_reg, den_next;
    logic                      zero_reg, zero_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [REM_W-1:0]          dsh_reg, dsh_next;
    logic [QUOT_W-1:0]         quot_reg, quot_next;
    logic [jets_pkg::STEP_W-1:0] step_reg, step_next;

    logic                      ge;
    logic [REM_W-1:0]          diff_ext;

    // shared compare/subtract unit
    assign ge       = (rem_reg >= dsh_reg);
    assign diff_ext = REM_W'(diff_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            jets_pkg::SC_IDLE: if (req.start) state_next = jets_pkg::SC_SUB;
            jets_pkg::SC_SUB:  state_next = jets_pkg::SC_ABS;
            jets_pkg::SC_ABS:  state_next = jets_pkg::SC_MUL;
            jets_pkg::SC_MUL:  state_next = jets_pkg::SC_DIV;
            jets_pkg::SC_DIV:  if (step_reg == '0) state_next = jets_pkg::SC_DONE;
            jets_pkg::SC_DONE: state_next = jets_pkg::SC_IDLE;
            default:           state_next = jets_pkg::SC_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        diff_next = diff_reg;
        den_next  = den_reg;
        zero_next = zero_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        case (state_reg)
            jets_pkg::SC_IDLE: begin
                diff_next = {req.value[31], req.value} - {req.lo[31], req.lo};
                den_next  = {req.hi[31], req.hi} - {req.lo[31], req.lo};
            end
            jets_pkg::SC_SUB: begin
                // negative or zero quotient, or an empty range, clamps to zero
                zero_next = (den_reg == '0) || (diff_reg == '0)
                            || (diff_reg[DIFF_W-1] != den_reg[DIFF_W-1]);
                diff_next = diff_reg[DIFF_W-1] ? (~diff_reg + 1'b1) : diff_reg;
                den_next  = den_reg[DIFF_W-1] ? (~den_reg + 1'b1) : den_reg;
            end
            jets_pkg::SC_ABS: begin
                // 2047 * |diff| as a shift and subtract
                rem_next  = (diff_ext << AXIS_W) - diff_ext;
                dsh_next  = REM_W'(den_reg) << AXIS_W;
                quot_next = '0;
                step_next = jets_pkg::LAST_STEP;
            end
            jets_pkg::SC_MUL: begin
                rem_next = rem_reg;
            end
            jets_pkg::SC_DIV: begin
                if (ge) begin
                    rem_next = rem_reg - dsh_reg;
                end
                quot_next = {quot_reg[QUOT_W-2:0], ge};
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg - 1'b1;
            end
            default: begin
                step_next = step_reg;
            end
        endcase
    end

    // outputs
    always_comb begin
        rsp.done   = (state_reg == jets_pkg::SC_DONE);
        if (zero_reg) begin
            rsp.result = '0;
        end else if (quot_reg[QUOT_W-1]) begin
            rsp.result = jets_pkg::AXIS_FULL;
        end else begin
            rsp.result = quot_reg[AXIS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= jets_pkg::SC_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        diff_reg <= diff_next;
        den_reg  <= den_next;
        zero_reg <= zero_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
        step_reg <= step_next;
    end

endmodule

/* rtl/joystick_event_tracker_scaler_top.sv */
`timescale 1ns / 1ps
// an event beat leaves the sequencer in ST_IDLE, so s_ready stays high
// a read beat runs ST_X_GO, ST_X_WAIT, ST_Y_GO, ST_Y_WAIT; ST_OUT then sets m_valid
// s_ready stays low until a read is through, the single scaler doing x then y
// reset: aresetn synchronous active low; buttons and axes clear, button codes
// reset to 288..291, both ranges to 0..2047, no beat pending on m_
module joystick_event_tracker_scaler_top (
    input  logic                            aclk,
    input  logic                            aresetn,

    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [jets_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [jets_pkg::RAW_W-1:0]      cfg_wdata,

    // input beats
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_cmd,
    input  logic [jets_pkg::EV_W-1:0]       s_event_type,
    input  logic [jets_pkg::EV_W-1:0]       s_event_code,
    input  logic signed [jets_pkg::RAW_W-1:0] s_event_value,

    // result beats
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [jets_pkg::STATUS_W-1:0]   m_status_word
);

    localparam int NUM_BTN = jets_pkg::NUM_BTN;
    localparam int AXIS_W  = jets_pkg::AXIS_W;
    localparam int RAW_W   = jets_pkg::RAW_W;

    jets_pkg::jets_cfg_t     cfg;
    jets_pkg::jets_scl_req_t scl_req;
    jets_pkg::jets_scl_rsp_t scl_rsp;

    jets_pkg::jets_state_t state_reg, state_next;

    // tracked joystick state
    logic [NUM_BTN-1:0] btn_reg, btn_next;
    logic [RAW_W-1:0]   axis_x_reg, axis_x_next;
    logic [RAW_W-1:0]   axis_y_reg, axis_y_next;

    // scaled x held while y is worked out
    logic [AXIS_W-1:0]  x_scaled_reg, x_scaled_next;

    // output stage
    logic                          m_valid_reg, m_valid_next;
    logic [jets_pkg::STATUS_W-1:0] m_status_word_reg, m_status_word_next;

    logic s_accept;
    logic out_load;

    jets_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    jets_scaler u_scaler (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (scl_req),
        .rsp     (scl_rsp)
    );

    assign s_accept = s_valid && s_ready;

    // next state of the read sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            jets_pkg::ST_IDLE: begin
                if (s_accept && (s_cmd == jets_pkg::CMD_READ)) begin
                    state_next = jets_pkg::ST_X_GO;
                end
            end
            jets_pkg::ST_X_GO:   state_next = jets_pkg::ST_X_WAIT;
            jets_pkg::ST_X_WAIT: if (scl_rsp.done) state_next = jets_pkg::ST_Y_GO;
            jets_pkg::ST_Y_GO:   state_next = jets_pkg::ST_Y_WAIT;
            jets_pkg::ST_Y_WAIT: if (scl_rsp.done) state_next = jets_pkg::ST_OUT;
            jets_pkg::ST_OUT:    if (!m_valid_reg || m_ready) state_next = jets_pkg::ST_IDLE;
            default:             state_next = jets_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake, scaler request, output load
    always_comb begin
        s_ready       = (state_reg == jets_pkg::ST_IDLE);
        scl_req.start = 1'b0;
        scl_req.value = axis_x_reg;
        scl_req.lo    = cfg.x_min;
        scl_req.hi    = cfg.x_max;
        out_load      = 1'b0;
        case (state_reg)
            jets_pkg::ST_X_GO: begin
                scl_req.start = 1'b1;
            end
            jets_pkg::ST_Y_GO: begin
                scl_req.start = 1'b1;
                scl_req.value = axis_y_reg;
                scl_req.lo    = cfg.y_min;
                scl_req.hi    = cfg.y_max;
            end
            jets_pkg::ST_OUT: begin
                // the output register frees up as the waiting beat leaves
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    // event tracking: key events set or clear every matching button,
    // absolute events on axis 0 or 1 store the raw position
    always_comb begin
        btn_next    = btn_reg;
        axis_x_next = axis_x_reg;
        axis_y_next = axis_y_reg;
        if (s_accept && (s_cmd == jets_pkg::CMD_EVENT)) begin
            if (s_event_type == jets_pkg::TYPE_KEY) begin
                for (int j = 0; j < NUM_BTN; j++) begin
                    if (s_event_code == jets_pkg::EV_W'(cfg.btn_code[j])) begin
                        btn_next[j] = (s_event_value != '0);
                    end
                end
            end else if (s_event_type == jets_pkg::TYPE_ABS) begin
                if (s_event_code == jets_pkg::CODE_X) begin
                    axis_x_next = s_event_value;
                end else if (s_event_code == jets_pkg::CODE_Y) begin
                    axis_y_next = s_event_value;
                end
            end
        end
    end

    // capture scaled x, then pack the status word
    always_comb begin
        x_scaled_next = x_scaled_reg;
        if ((state_reg == jets_pkg::ST_X_WAIT) && scl_rsp.done) begin
            x_scaled_next = scl_rsp.result;
        end
    end

    always_comb begin
        m_status_word_next = m_status_word_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        if ((state_reg == jets_pkg::ST_Y_WAIT) && scl_rsp.done) begin
            // bit 27 valid, bit 26 zero, buttons, y, x
            m_status_word_next = {1'b1, 1'b0, btn_reg, scl_rsp.result, x_scaled_reg};
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= jets_pkg::ST_IDLE;
            btn_reg     <= '0;
            axis_x_reg  <= '0;
            axis_y_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            btn_reg     <= btn_next;
            axis_x_reg  <= axis_x_next;
            axis_y_reg  <= axis_y_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // the word is built while the previous one may still wait, so it is
    // staged until ST_OUT loads it
    logic [jets_pkg::STATUS_W-1:0] word_stage_reg;

    always_ff @(posedge aclk) begin
        x_scaled_reg   <= x_scaled_next;
        word_stage_reg <= (state_reg == jets_pkg::ST_Y_WAIT) ? m_status_word_next
                                                             : word_stage_reg;
        if (out_load) begin
            m_status_word_reg <= word_stage_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status_word = m_status_word_reg;

endmodule

/* rtl/jets_checker.sv */
`timescale 1ns / 1ps
// jets_checker: port-level checks of the joystick tracker and its bind
// depends on jets_pkg and joystick_event_tracker_scaler_top
module jets_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            s_cmd,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [jets_pkg::STATUS_W-1:0]   m_status_word
);

    // a waiting result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status_word))
    else $error("result beat dropped or changed while stalled");

    // every result carries the valid flag and a zero bit 26
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status_word[27] && !m_status_word[26])
    else $error("status word flag bits wrong");

    // a read keeps the input side busy while it is scaled
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_cmd == jets_pkg::CMD_READ) |=> !s_ready)
    else $error("input taken during a read");

    // an event beat never makes a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_cmd == jets_pkg::CMD_EVENT) && !m_valid |=> !m_valid)
    else $error("result from an event beat");

    // nothing pending right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
    else $error("result beat pending after reset");

endmodule

bind joystick_event_tracker_scaler_top jets_checker u_jets_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_cmd         (s_cmd),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status_word (m_status_word)
);

/* sim/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for joystick_event_tracker_scaler_top, random and directed beats
// depends on rtl/jets_pkg.sv and rtl/joystick_event_tracker_scaler_top.sv
module testbench;

    localparam int EV_W      = jets_pkg::EV_W;
    localparam int RAW_W     = jets_pkg::RAW_W;
    localparam int CODE_W    = jets_pkg::CODE_W;
    localparam int AXIS_W    = jets_pkg::AXIS_W;
    localparam int STATUS_W  = jets_pkg::STATUS_W;
    localparam int NUM_BTN   = jets_pkg::NUM_BTN;
    localparam int REG_IDX_W = jets_pkg::REG_IDX_W;

    // run guard, far above the slowest legal run of this stimulus
    localparam int CYCLE_LIMIT  = 1_000_000;
    // drain time after the last beat, enough for a read beat to come out
    localparam int DRAIN_CYCLES = 48;
    // one long receiver hold-off, long enough to back the block up
    localparam int LONG_HOLD    = 800;
    localparam int PHASE_BEATS  = 190;

    typedef struct {
        logic             cmd;
        logic [EV_W-1:0]  etype;
        logic [EV_W-1:0]  ecode;
        logic [RAW_W-1:0] evalue;
    } joy_beat_t;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_TIGHT,
        RX_PERIODIC
    } rx_mode_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index     = jets_pkg::REG_BTN_A;
    logic [RAW_W-1:0]     cfg_wdata     = '0;
    logic                 s_valid       = 1'b0;
    wire                  s_ready;
    logic                 s_cmd         = jets_pkg::CMD_EVENT;
    logic [EV_W-1:0]      s_event_type  = '0;
    logic [EV_W-1:0]      s_event_code  = '0;
    logic [RAW_W-1:0]     s_event_value = '0;
    wire                  m_valid;
    logic                 m_ready       = 1'b0;
    wire  [STATUS_W-1:0]  m_status_word;

    joystick_event_tracker_scaler_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_event_type  (s_event_type),
        .s_event_code  (s_event_code),
        .s_event_value (s_event_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status_word (m_status_word)
    );

    always #2 aclk = ~aclk;

    // beats waiting to be offered on s_, filled by the stimulus block
    joy_beat_t pending_beats[$];
    // status words the block owes us, oldest first
    logic [STATUS_W-1:0] status_due[$];

    // set at each posedge where an s_ beat went in, cleared at one where none did
    logic in_taken = 1'b0;

    // mirror of the register file and of the tracked joystick
    logic [RAW_W-1:0]   reg_copy [8];
    logic [NUM_BTN-1:0] btn_state;
    logic [RAW_W-1:0]   raw_x;
    logic [RAW_W-1:0]   raw_y;

    // what the stimulus side last programmed, used only to aim random beats
    int     plan_code [NUM_BTN];
    longint plan_xlo, plan_xhi, plan_ylo, plan_yhi;

    int fail_count  = 0;
    int cycle_count = 0;

    // long hold-off requests from the stimulus block, served by the receiver
    int hold_reqs    = 0;
    int holds_served = 0;

    // linear map of a raw position onto 0..2047, clamped, 0 on an empty range
    function automatic logic [AXIS_W-1:0] scaled_axis(input logic [RAW_W-1:0] raw,
                                                      input logic [RAW_W-1:0] lo,
                                                      input logic [RAW_W-1:0] hi);
        longint v, mn, mx, q, full;
        full = jets_pkg::AXIS_FULL;
        v    = $signed(raw);
        mn   = $signed(lo);
        mx   = $signed(hi);
        if (mx == mn) begin
            return '0;
        end
        // signed 64-bit division truncates toward zero, as the scaler's divider does
        q = (full * (v - mn)) / (mx - mn);
        if (q < 0) begin
            return '0;
        end
        if (q > full) begin
            return jets_pkg::AXIS_FULL;
        end
        return q[AXIS_W-1:0];
    endfunction

    // update the tracked joystick with one accepted beat, queue the status word on a read
    task automatic track_joystick(input joy_beat_t b);
        logic [AXIS_W-1:0] sx, sy;
        if (b.cmd == jets_pkg::CMD_EVENT) begin
            if (b.etype == jets_pkg::TYPE_KEY) begin
                // every button whose code matches follows the level, nonzero means pressed
                for (int j = 0; j < NUM_BTN; j++) begin
                    if (b.ecode == reg_copy[j][EV_W-1:0]) begin
                        btn_state[j] = (b.evalue != '0);
                    end
                end
            end else if (b.etype == jets_pkg::TYPE_ABS) begin
                if (b.ecode == jets_pkg::CODE_X) begin
                    raw_x = b.evalue;
                end else if (b.ecode == jets_pkg::CODE_Y) begin
                    raw_y = b.evalue;
                end
            end
        end else begin
            sx = scaled_axis(raw_x, reg_copy[jets_pkg::REG_X_MIN],
                             reg_copy[jets_pkg::REG_X_MAX]);
            sy = scaled_axis(raw_y, reg_copy[jets_pkg::REG_Y_MIN],
                             reg_copy[jets_pkg::REG_Y_MAX]);
            status_due.push_back({1'b1, 1'b0, btn_state, sy, sx});
        end
    endtask

    // ------------------------------------------------------------------
    // s_ driver: bursts of random length, random gaps, payload held while waiting
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge aclk) begin : drive_s
        joy_beat_t b;
        logic      nxt_valid;
        nxt_valid = s_valid;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else if (!s_valid || in_taken) begin
            // previous beat is gone (or there was none), pick what comes next
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_beats.size() > 0) begin
                b = pending_beats.pop_front();
                s_cmd         <= b.cmd;
                s_event_type  <= b.etype;
                s_event_code  <= b.ecode;
                s_event_value <= b.evalue;
                nxt_valid = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    // a quarter of the bursts run straight into the next one
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
                end
            end
        end
        // single nonblocking write so a held valid never dips
        s_valid <= nxt_valid;
    end

    // ------------------------------------------------------------------
    // m_ receiver: stall pattern of its own, plus long hold-offs on request
    // ------------------------------------------------------------------
    int       hold_left = 0;
    int       rx_span   = 0;
    int       rx_phase  = 0;
    rx_mode_t rx_mode   = RX_OPEN;

    always @(negedge aclk) begin : drive_m
        logic nxt_ready;
        nxt_ready = 1'b0;
        if (hold_left > 0) begin
            hold_left--;
        end else if (holds_served != hold_reqs) begin
            holds_served++;
            hold_left = LONG_HOLD;
        end else begin
            if (rx_span == 0) begin
                rx_span = $urandom_range(1, 80);
                rx_mode = rx_mode_t'($urandom_range(0, 3));
            end
            rx_span--;
            rx_phase++;
            case (rx_mode)
                RX_OPEN: begin
                    nxt_ready = 1'b1;
                end
                RX_COIN: begin
                    nxt_ready = 1'($urandom_range(0, 1));
                end
                RX_TIGHT: begin
                    nxt_ready = ($urandom_range(0, 7) == 0);
                end
                default: begin
                    nxt_ready = (rx_phase % 5) < 2;
                end
            endcase
        end
        m_ready <= nxt_ready;
    end

    // ------------------------------------------------------------------
    // checker: sample at posedge, compare results first, then predict
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : watch
        logic [STATUS_W-1:0] want;
        joy_beat_t           b;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            in_taken <= aresetn && s_valid && s_ready;
            if (!aresetn) begin
                // reset values of the register file and the joystick
                reg_copy[jets_pkg::REG_BTN_A] = 32'd288;
                reg_copy[jets_pkg::REG_BTN_B] = 32'd289;
                reg_copy[jets_pkg::REG_BTN_C] = 32'd290;
                reg_copy[jets_pkg::REG_BTN_D] = 32'd291;
                reg_copy[jets_pkg::REG_X_MIN] = 32'd0;
                reg_copy[jets_pkg::REG_X_MAX] = 32'd2047;
                reg_copy[jets_pkg::REG_Y_MIN] = 32'd0;
                reg_copy[jets_pkg::REG_Y_MAX] = 32'd2047;
                btn_state = '0;
                raw_x     = '0;
                raw_y     = '0;
            end else begin
                // a result cannot leave on the edge its read went in, so pop before push
                if (m_valid && m_ready) begin
                    if (status_due.size() == 0) begin
                        $error("status_word beat with nothing due: expected none, actual %h",
                               m_status_word);
                        fail_count++;
                    end else begin
                        want = status_due.pop_front();
                        if (m_status_word !== want) begin
                            $error("status_word mismatch: expected %h, actual %h",
                                   want, m_status_word);
                            fail_count++;
                        end
                    end
                end
                if (cfg_wr_en) begin
                    // button codes keep 10 bits, the range registers keep all 32
                    if (cfg_index <= jets_pkg::REG_BTN_D) begin
                        reg_copy[cfg_index] = {{(RAW_W-CODE_W){1'b0}}, cfg_wdata[CODE_W-1:0]};
                    end else begin
                        reg_copy[cfg_index] = cfg_wdata;
                    end
                end
                if (s_valid && s_ready) begin
                    b.cmd    = s_cmd;
                    b.etype  = s_event_type;
                    b.ecode  = s_event_code;
                    b.evalue = s_event_value;
                    track_joystick(b);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_beat(input logic cmd, input logic [EV_W-1:0] etype,
                             input logic [EV_W-1:0] ecode, input logic [RAW_W-1:0] evalue);
        joy_beat_t b;
        b.cmd    = cmd;
        b.etype  = etype;
        b.ecode  = ecode;
        b.evalue = evalue;
        pending_beats.push_back(b);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [RAW_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
    endtask

    // full register file rewrite, only called while the block is idle
    task automatic program_regs(input int ca, input int cb, input int cc, input int cd,
                                input longint xlo, input longint xhi,
                                input longint ylo, input longint yhi);
        logic [RAW_W-1:0] w;
        write_reg(jets_pkg::REG_BTN_A, ca);
        write_reg(jets_pkg::REG_BTN_B, cb);
        write_reg(jets_pkg::REG_BTN_C, cc);
        write_reg(jets_pkg::REG_BTN_D, cd);
        w = xlo[RAW_W-1:0];
        write_reg(jets_pkg::REG_X_MIN, w);
        plan_xlo = $signed(w);
        w = xhi[RAW_W-1:0];
        write_reg(jets_pkg::REG_X_MAX, w);
        plan_xhi = $signed(w);
        w = ylo[RAW_W-1:0];
        write_reg(jets_pkg::REG_Y_MIN, w);
        plan_ylo = $signed(w);
        w = yhi[RAW_W-1:0];
        write_reg(jets_pkg::REG_Y_MAX, w);
        plan_yhi = $signed(w);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        plan_code[0] = ca;
        plan_code[1] = cb;
        plan_code[2] = cc;
        plan_code[3] = cd;
    endtask

    // everything offered, everything owed delivered, then room for a trailing event
    task automatic wait_drained();
        while (pending_beats.size() != 0 || s_valid || status_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // mostly well-formed traffic aimed at the current setup, the rest noise
    task automatic random_phase(input int n);
        int              pick, frac;
        longint          lo, hi, v;
        logic [RAW_W-1:0] lvl;
        logic            axis;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 28) begin
                // read, with junk in the fields it must ignore
                push_beat(jets_pkg::CMD_READ, EV_W'($urandom), EV_W'($urandom), $urandom);
            end else if (pick < 58) begin
                // key event on one of the programmed codes
                case ($urandom_range(0, 3))
                    0: begin
                        lvl = '0;
                    end
                    1: begin
                        lvl = 32'd1;
                    end
                    2: begin
                        lvl = 32'd2;
                    end
                    default: begin
                        lvl = $urandom;
                    end
                endcase
                push_beat(jets_pkg::CMD_EVENT, jets_pkg::TYPE_KEY,
                          EV_W'(plan_code[$urandom_range(0, NUM_BTN-1)]), lvl);
            end else if (pick < 88) begin
                // axis event, mostly inside or just around the programmed range
                axis = 1'($urandom_range(0, 1));
                lo   = axis ? plan_ylo : plan_xlo;
                hi   = axis ? plan_yhi : plan_xhi;
                case ($urandom_range(0, 7))
                    0: begin
                        v = lo;
                    end
                    1: begin
                        v = hi;
                    end
                    2: begin
                        v = $signed($urandom);
                    end
                    default: begin
                        frac = $urandom_range(0, 1200);
                        frac = frac - 100;
                        v = lo + ((hi - lo) * frac) / 1000;
                    end
                endcase
                push_beat(jets_pkg::CMD_EVENT, jets_pkg::TYPE_ABS,
                          axis ? jets_pkg::CODE_Y : jets_pkg::CODE_X, v[RAW_W-1:0]);
            end else begin
                // noise: odd types, wide codes, unknown axes
                case ($urandom_range(0, 2))
                    0: begin
                        push_beat(jets_pkg::CMD_EVENT, EV_W'($urandom), EV_W'($urandom),
                                  $urandom);
                    end
                    1: begin
                        push_beat(jets_pkg::CMD_EVENT, jets_pkg::TYPE_KEY, EV_W'($urandom),
                                  $urandom);
                    end
                    default: begin
                        push_beat(jets_pkg::CMD_EVENT, jets_pkg::TYPE_ABS, EV_W'($urandom),
                                  $urandom);
                    end
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        longint xa, xb, ya, yb;
        plan_code[0] = 288;
        plan_code[1] = 289;
        plan_code[2] = 290;
        plan_code[3] = 291;
        plan_xlo = 0;
        plan_xhi = 2047;
        plan_ylo = 0;
        plan_yhi = 2047;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed, on reset register values; all clear after reset
        push_beat(jets_pkg::CMD_READ, '0, '0, '0);
        push_beat(jets_pkg::CMD_EVENT, jets_pkg::TYPE_KEY, 16'd288, 32'd1);
        // level 2 still means pressed
        push_beat(jets_pkg::CMD_EVENT, jets_pkg::TYPE_KEY, 16'd289, 32'd2);
        push_beat(jets_pkg::CMD_EVENT, jets_pkg::TYPE_KEY, 16'd290, 32'hFFFF_FFFF);
        push_beat(jets_pkg::CMD_EVENT, jets_pkg::TYPE_KEY, 16'd291, 32'h8000_0000);
        push_beat(jets_pkg::CMD_READ, '0, '0, '0);
        // release
        push_beat(jets_pkg::CMD_EVENT, jets_pkg::TYPE_KEY, 16'd288, 32'd0);
        // 288 plus 1024, must not match
        push_beat(jets_pkg::CMD_EVENT, jets_pkg::TYPE_KEY, 16'd1312, 32'd1);
        push_beat(jets_pkg::CMD_EVENT, jets_pkg::TYPE_KEY, 16'hFFFF, 32'd1);
        push_beat(jets_pkg::CMD_READ, '0, '0, '0);
        push_beat(jets_pkg::CMD_EVENT, jets_pkg::TYPE_ABS, jets_pkg::CODE_X, 32'd2047);
        push_beat(jets_pkg::CMD_EVENT, jets_pkg::TYPE_ABS, jets_pkg::CODE_Y, 32'd1023);
        // read ignores its payload
        push_beat(jets_pkg::CMD_READ, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF);
        // clamps low, then clamps high
        push_beat(jets_pkg::CMD_EVENT, jets_pkg::TYPE_ABS, jets_pkg::CODE_X, 32'h8000_0000);
        push_beat(jets_pkg::CMD_EVENT, jets_pkg::TYPE_ABS, jets_pkg::CODE_Y, 32'h7FFF_FFFF);
        push_beat(jets_pkg::CMD_READ, jets_pkg::TYPE_ABS, jets_pkg::CODE_X, 32'd12345);
        // unknown type, unknown axis, more odd types
        push_beat(jets_pkg::CMD_EVENT, 16'd2, jets_pkg::CODE_X, 32'd5);
        push_beat(jets_pkg::CMD_EVENT, jets_pkg::TYPE_ABS, 16'd2, 32'd7);
        push_beat(jets_pkg::CMD_EVENT, 16'd0, jets_pkg::CODE_Y, 32'd9);
        push_beat(jets_pkg::CMD_EVENT, 16'hFFFF, jets_pkg::CODE_X, 32'hFFFF_FFFF);
        push_beat(jets_pkg::CMD_READ, '0, '0, '0);
        push_beat(jets_pkg::CMD_EVENT, jets_pkg::TYPE_ABS, jets_pkg::CODE_X, 32'd1);
        push_beat(jets_pkg::CMD_EVENT, jets_pkg::TYPE_ABS, jets_pkg::CODE_Y, 32'd2046);
        push_beat(jets_pkg::CMD_EVENT, jets_pkg::TYPE_KEY, 16'd289, 32'd0);
        push_beat(jets_pkg::CMD_READ, '0, '0, '0);
        wait_drained();

        // all buttons on one code, full-scale X, full-scale inverted Y
        program_regs(5, 5, 5, 5, -64'sd2147483648, 64'sd2147483647,
                     64'sd2147483647, -64'sd2147483648);
        random_phase(PHASE_BEATS);
        wait_drained();

        // empty X range, one-step Y range, codes 0 and 767; receiver backs up here
        program_regs(0, 767, 0, 767, 100, 100, -1000, -999);
        hold_reqs++;
        random_phase(PHASE_BEATS);
        wait_drained();

        // narrow negative X range, unit Y range
        program_regs(767, 766, 1, 2, -2047, 0, 0, 1);
        random_phase(PHASE_BEATS);
        wait_drained();

        // random setups, some narrow, some anywhere in 32 bits
        for (int p = 0; p < 3; p++) begin
            xa = $signed($urandom);
            xb = $urandom_range(0, 1) ? xa + $urandom_range(0, 5000) : $signed($urandom);
            ya = $signed($urandom);
            yb = $urandom_range(0, 1) ? ya + $urandom_range(0, 5000) : $signed($urandom);
            program_regs($urandom_range(0, 767), $urandom_range(0, 767),
                         $urandom_range(0, 767), $urandom_range(0, 767), xa, xb, ya, yb);
            if (p == 1) begin
                hold_reqs++;
            end
            random_phase(PHASE_BEATS);
            wait_drained();
        end

        // back to the reset setup
        program_regs(288, 289, 290, 291, 0, 2047, 0, 2047);
        random_phase(PHASE_BEATS);
        wait_drained();

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
